FILE: rtl/fcc_pkg.sv
`timescale 1ns / 1ps
// shared types, status codes and crc constants for the frame crc-16 checker
// no dependencies; used by every module of the block and by its checker

package fcc_pkg;

    // crc-16 parameters: poly 0x1021, init 0xffff, msb first, no final xor
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // check status codes
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_MISMATCH = 2'd1;
    localparam logic [1:0] STATUS_SHORT    = 2'd2;

    // held byte count, 0..2
    localparam logic [1:0] HELD_FULL = 2'd2;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_last;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [1:0]  check_status;
        logic [15:0] computed_crc;
        logic [15:0] received_crc;
    } result_t;

    // one byte through the crc, msb first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

FILE: rtl/fcc_input_reg.sv
`timescale 1ns / 1ps
// input register stage of the frame crc-16 checker
// depends on fcc_pkg for the input item type

module fcc_input_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  fcc_pkg::in_item_t item,
    output logic             stage_valid,
    output fcc_pkg::in_item_t stage_item,
    input  logic             stage_go
);

    logic              valid_reg;
    logic              valid_next;
    fcc_pkg::in_item_t item_reg;

    // take a new item whenever the stage is empty or moving on
    assign item_ready = !valid_reg || stage_go;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_valid && item_ready)
        begin
            valid_next = 1'b1;
        end
        else if (stage_go)
        begin
            valid_next = 1'b0;
        end
    end

    // control flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holds until replaced
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

FILE: rtl/fcc_frame_core.sv
`timescale 1ns / 1ps
// frame state, crc byte update, check and result register
// depends on fcc_pkg for types, constants and the crc byte function

module fcc_frame_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              stage_valid,
    input  fcc_pkg::in_item_t stage_item,
    output logic              stage_go,
    output logic              result_valid,
    input  logic              result_ready,
    output fcc_pkg::result_t  result
);

    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [7:0]       held0_reg;
    logic [7:0]       held0_next;
    logic [7:0]       held1_reg;
    logic [7:0]       held1_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             res_valid_reg;
    logic             res_valid_next;
    fcc_pkg::result_t res_reg;
    fcc_pkg::result_t res_next;
    logic             out_free;
    logic [15:0]      crc_fed;
    logic [15:0]      rx_crc;

    // a last byte needs room in the result register, others always move on
    assign out_free = !res_valid_reg || result_ready;
    assign stage_go = stage_valid && (!stage_item.frame_last || out_free);

    // oldest held byte enters the crc once two are held
    assign crc_fed = (count_reg == fcc_pkg::HELD_FULL) ?
                     fcc_pkg::crc_feed(crc_reg, held0_reg) : crc_reg;
    assign rx_crc  = {held1_reg, stage_item.data_byte};

    // next state and result
    always_comb
    begin
        crc_next       = crc_reg;
        held0_next     = held0_reg;
        held1_next     = held1_reg;
        count_next     = count_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        if (result_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (stage_go)
        begin
            if (!stage_item.frame_last)
            begin
                crc_next   = crc_fed;
                held0_next = held1_reg;
                held1_next = stage_item.data_byte;
                if (count_reg != fcc_pkg::HELD_FULL)
                begin
                    count_next = count_reg + 2'd1;
                end
            end
            else
            begin
                res_valid_next = 1'b1;
                if (count_reg == 2'd0)
                begin
                    res_next.check_status = fcc_pkg::STATUS_SHORT;
                    res_next.computed_crc = fcc_pkg::CRC_INIT;
                    res_next.received_crc = 16'd0;
                end
                else
                begin
                    res_next.check_status = (rx_crc == crc_fed) ?
                                            fcc_pkg::STATUS_OK : fcc_pkg::STATUS_MISMATCH;
                    res_next.computed_crc = crc_fed;
                    res_next.received_crc = rx_crc;
                end
                // back to the start of a frame
                crc_next   = fcc_pkg::CRC_INIT;
                held0_next = 8'd0;
                held1_next = 8'd0;
                count_next = 2'd0;
            end
        end
    end

    // frame state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= fcc_pkg::CRC_INIT;
            held0_reg     <= 8'd0;
            held1_reg     <= 8'd0;
            count_reg     <= 2'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            held0_reg     <= held0_next;
            held1_reg     <= held1_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

FILE: rtl/frame_crc16_checker.sv
`timescale 1ns / 1ps
// top level of the frame crc-16 checker
// depends on fcc_pkg, fcc_input_reg and fcc_frame_core

// Checks frames of bytes ending in a big-endian CRC-16/CCITT-FALSE (poly 0x1021,
// init 0xFFFF, msb first, no final xor). One byte item is accepted per cycle;
// the last byte of a frame (frame_last) yields one result item: it is held in
// the input register, and once the result register has room the 8-step crc
// byte update and compare are written into the result register.
// Non-last bytes yield nothing. The input stalls only while a finished result
// waits in the result register and a last byte is behind it. A frame of fewer
// than two bytes reports status 2 with computed crc 0xFFFF and received crc 0.

module frame_crc16_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  fcc_pkg::in_item_t item,
    output logic              result_valid,
    input  logic              result_ready,
    output fcc_pkg::result_t  result
);

    logic              stage_valid;
    logic              stage_go;
    fcc_pkg::in_item_t stage_item;

    // input register
    fcc_input_reg u_input_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .stage_valid(stage_valid),
        .stage_item (stage_item),
        .stage_go   (stage_go)
    );

    // frame state, crc and result register
    fcc_frame_core u_frame_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_valid (stage_valid),
        .stage_item  (stage_item),
        .stage_go    (stage_go),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

endmodule

FILE: rtl/fcc_checker.sv
`timescale 1ns / 1ps
// port-level checker for the frame crc-16 checker, bound to the top level
// depends on fcc_pkg for the status codes and crc constants

module fcc_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input fcc_pkg::result_t result
);

    // a waiting result item holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result item changed or dropped while stalled");

    // status is consistent with the two crcs
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.check_status == fcc_pkg::STATUS_OK
        |-> result.computed_crc == result.received_crc)
    else $error("ok status with differing crcs");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.check_status == fcc_pkg::STATUS_MISMATCH
        |-> result.computed_crc != result.received_crc)
    else $error("mismatch status with equal crcs");

    // short frame reports empty-payload crc and no received crc
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.check_status == fcc_pkg::STATUS_SHORT
        |-> result.computed_crc == fcc_pkg::CRC_INIT && result.received_crc == 16'd0)
    else $error("short frame result carries wrong crc fields");

    // no undefined status code
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> result.check_status != 2'd3)
    else $error("undefined check status");

endmodule

bind frame_crc16_checker fcc_checker u_fcc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for frame_crc16_checker: directed and random frames
// depends on fcc_pkg and the rtl of frame_crc16_checker; predicts every verdict itself

module tb_top;

    localparam int CLK_HALF     = 6;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 400;

    logic              clk          = 1'b0;
    logic              rst_n        = 1'b0;
    logic              item_valid   = 1'b0;
    logic              item_ready;
    fcc_pkg::in_item_t item         = '0;
    logic              result_valid;
    logic              result_ready = 1'b0;
    fcc_pkg::result_t  result;

    // predicted checker state
    logic [15:0] model_crc;
    logic [7:0]  model_held [2];
    logic [1:0]  model_held_cnt;

    // verdicts still owed by the block, oldest first
    fcc_pkg::result_t expected_verdicts [$];
    fcc_pkg::result_t verdict_want;
    logic [7:0]       frame_bytes [$];

    int          error_count  = 0;
    int          items_sent   = 0;
    int          burst_left   = 0;
    bit          sender_gaps_on     = 1'b0;
    bit          receiver_stalls_on = 1'b1;
    int          hold_request = 0;
    int          hold_left    = 0;
    logic [15:0] stall_pattern = 16'hFFFF;
    int          pattern_age  = 0;

    frame_crc16_checker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // clock
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // crc-16 over one byte, msb first
    function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int k = 7; k >= 0; k--)
        begin
            c = {c[14:0], 1'b0} ^
                (((c[15] ^ b[k]) == 1'b1) ? fcc_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    task automatic clear_model();
        model_crc      = fcc_pkg::CRC_INIT;
        model_held[0]  = 8'h00;
        model_held[1]  = 8'h00;
        model_held_cnt = 2'd0;
    endtask

    // advance the predicted state by one accepted byte
    task automatic predict_frame_byte(input logic [7:0] data, input logic last);
        fcc_pkg::result_t v;
        logic [15:0]      rx;
        if (model_held_cnt == fcc_pkg::HELD_FULL)
        begin
            model_crc = crc16_next(model_crc, model_held[0]);
        end
        if (!last)
        begin
            model_held[0] = model_held[1];
            model_held[1] = data;
            if (model_held_cnt < fcc_pkg::HELD_FULL)
            begin
                model_held_cnt = model_held_cnt + 2'd1;
            end
        end
        else
        begin
            if (model_held_cnt == 2'd0)
            begin
                v.check_status = fcc_pkg::STATUS_SHORT;
                v.computed_crc = fcc_pkg::CRC_INIT;
                v.received_crc = 16'h0000;
            end
            else
            begin
                rx             = {model_held[1], data};
                v.check_status = (rx == model_crc) ?
                                 fcc_pkg::STATUS_OK : fcc_pkg::STATUS_MISMATCH;
                v.computed_crc = model_crc;
                v.received_crc = rx;
            end
            expected_verdicts.push_back(v);
            clear_model();
        end
    endtask

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // offer one item and hold it until accepted; gaps come between bursts
    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        if (sender_gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(6, 1);
                item_valid <= 1'b0;
                item       <= {8'($urandom), 1'($urandom)};
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(24, 1);
            end
            burst_left--;
        end
        item_valid <= 1'b1;
        item       <= {data, last};
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
        predict_frame_byte(data, last);
        items_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
        begin
            send_byte(frame_bytes[i], (i == frame_bytes.size() - 1));
        end
    endtask

    // append the big-endian crc of the bytes gathered so far
    task automatic append_crc();
        logic [15:0] c;
        c = fcc_pkg::CRC_INIT;
        foreach (frame_bytes[i])
        begin
            c = crc16_next(c, frame_bytes[i]);
        end
        frame_bytes.push_back(c[15:8]);
        frame_bytes.push_back(c[7:0]);
    endtask

    // one-byte and two-byte frames, payload empty
    task automatic test_short_frames();
        frame_bytes = {8'h00};
        send_frame();
        frame_bytes = {8'hFF};
        send_frame();
        frame_bytes = {8'hFF, 8'hFF};
        send_frame();
        frame_bytes = {8'h00, 8'h00};
        send_frame();
        frame_bytes = {8'hFF, 8'h00};
        send_frame();
    endtask

    // standard check string, extreme payload bytes, a corrupted crc
    task automatic test_payload_extremes();
        frame_bytes = {8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        append_crc();
        send_frame();
        frame_bytes = {8'h00};
        append_crc();
        send_frame();
        frame_bytes = {8'hFF};
        append_crc();
        frame_bytes[2] = frame_bytes[2] ^ 8'h80;
        send_frame();
    endtask

    // well-formed frames with random content for half the draws, the rest broken, one-byte or noise
    task automatic test_random_frames(input int n_items);
        int stop_at;
        int r;
        int len;
        int n;
        int pos;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(99, 0);
            frame_bytes.delete();
            if (r < 8)
            begin
                frame_bytes.push_back(8'($urandom));
                send_frame();
            end
            else if (r < 14)
            begin
                // noise: random last marks, closed by a last byte
                n = $urandom_range(10, 1);
                for (int i = 0; i < n; i++)
                begin
                    send_byte(8'($urandom), (i == n - 1) || ($urandom_range(4, 0) == 0));
                end
            end
            else
            begin
                len = ($urandom_range(99, 0) < 85) ? $urandom_range(8, 0) : $urandom_range(40, 9);
                for (int i = 0; i < len; i++)
                begin
                    frame_bytes.push_back(8'($urandom));
                end
                append_crc();
                if (r < 40)
                begin
                    pos = $urandom_range(frame_bytes.size() - 1, 0);
                    frame_bytes[pos] = frame_bytes[pos] ^ (8'h01 << $urandom_range(7, 0));
                end
                else if (r < 50)
                begin
                    frame_bytes[frame_bytes.size() - 1] = 8'($urandom);
                end
                send_frame();
            end
        end
    endtask

    // receiver holds off for a long stretch while short frames keep coming
    task automatic test_receiver_backpressure();
        hold_request = LONG_HOLD;
        for (int f = 0; f < 40; f++)
        begin
            frame_bytes.delete();
            if (f % 2 == 0)
            begin
                frame_bytes.push_back(8'($urandom));
            end
            else
            begin
                append_crc();
            end
            send_frame();
        end
    endtask

    // wait for every owed verdict, then a few more cycles for strays
    task automatic test_drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (expected_verdicts.size() > 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver: long hold on request, else always ready or a rotating stall pattern
    always @(posedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            result_ready <= 1'b0;
        end
        else if (!receiver_stalls_on)
        begin
            result_ready <= 1'b1;
        end
        else
        begin
            if (pattern_age == 0)
            begin
                stall_pattern = ($urandom_range(3, 0) == 0) ? 16'hFFFF : 16'($urandom);
                pattern_age   = 48;
            end
            pattern_age--;
            result_ready  <= stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
        end
    end

    // compare each accepted result with the oldest owed verdict
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                report_error($sformatf("result %h with no verdict owed", result));
            end
            else
            begin
                verdict_want = expected_verdicts.pop_front();
                if (result.check_status !== verdict_want.check_status)
                begin
                    report_error($sformatf("check_status got %0d expected %0d",
                                           result.check_status, verdict_want.check_status));
                end
                if (result.computed_crc !== verdict_want.computed_crc)
                begin
                    report_error($sformatf("computed_crc got %h expected %h",
                                           result.computed_crc, verdict_want.computed_crc));
                end
                if (result.received_crc !== verdict_want.received_crc)
                begin
                    report_error($sformatf("received_crc got %h expected %h",
                                           result.received_crc, verdict_want.received_crc));
                end
            end
        end
    end

    // test sequence
    initial
    begin
        clear_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frames();
        test_payload_extremes();

        sender_gaps_on = 1'b1;
        test_random_frames(600);

        sender_gaps_on     = 1'b0;
        receiver_stalls_on = 1'b0;
        test_random_frames(250);

        test_receiver_backpressure();

        sender_gaps_on     = 1'b1;
        receiver_stalls_on = 1'b1;
        test_random_frames(450);

        test_drain();

        if (error_count == 0 && expected_verdicts.size() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
